[rtl/cmbp_pkg.sv]
// Package for the bit packer: sequencer states, result beat type and widths.
// Used by cmbp_shift_unit, cmbp_out_stage and coap_message_bit_packer.
package cmbp_pkg;

    localparam int FIELD_W   = 64;
    localparam int COUNT_W   = 7;
    localparam int BYTE_W    = 8;
    localparam int PEND_W    = 7;
    localparam int PCNT_W    = 3;
    localparam int TAKE_W    = 4;
    localparam int SHAMT_W   = 7;
    localparam int IN_DATA_W = 72;

    localparam logic [COUNT_W-1:0] MAX_BITS  = 7'd64;
    localparam logic [TAKE_W-1:0]  BYTE_BITS = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ALIGN = 3'b010,
        ST_RUN   = 3'b100
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              message_last;
    } out_beat_t;

endpackage

[rtl/coap_message_bit_packer.sv]
// Top level of the message bit packer: sequencer, option delta and bit state.
// Depends on cmbp_pkg, cmbp_shift_unit and cmbp_out_stage.
//
// Usage:
//   s_axis carries one field per transaction: tdata holds field_value in
//   [63:0] and bit_count in [70:64], tuser is cmd, tlast is message_end.
//   m_axis carries one packed byte per transaction: tdata is the byte with
//   the first written bit in bit 7, tlast marks the last byte of a field,
//   tuser marks the final byte of the message.
//   An accepted field is registered (as its option delta when cmd is set),
//   left-aligned in ST_ALIGN, then packed in ST_RUN one step at a time:
//   one step for each byte boundary it crosses plus one for any remainder,
//   and at least one step, because the shared 64-bit shifter moves at most
//   one byte's worth of bits per step. A step that emits a byte waits until
//   the output register is free. s_axis_tready is high only while the
//   sequencer is idle. When m_axis stalls, a byte is held in the output
//   register and the sequencer waits; nothing is dropped. Reset empties the
//   output register and clears the partial byte, bit count and previous
//   option number.
module coap_message_bit_packer
    import cmbp_pkg::*;
#(
    parameter int OPTION_NUMBER_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata, // field_value, bit_count, zero pad
    input  logic                 s_axis_tuser, // cmd
    input  logic                 s_axis_tlast, // message_end
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [BYTE_W-1:0]    m_axis_tdata, // out_byte
    output logic                 m_axis_tlast, // run_last
    output logic                 m_axis_tuser  // message_last
);

    localparam int ONB = OPTION_NUMBER_BITS;

    state_t              state_reg, state_next;
    logic [FIELD_W-1:0]  val_reg, val_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [PEND_W-1:0]   acc_reg, acc_next;
    logic [PCNT_W-1:0]   cnt_reg, cnt_next;
    logic                end_reg, end_next;
    logic [ONB-1:0]      prev_reg, prev_next;

    logic                accept;
    logic [FIELD_W-1:0]  in_value;
    logic [COUNT_W-1:0]  in_count;
    logic [ONB-1:0]      opt_num;
    logic [ONB:0]        opt_diff;
    logic [TAKE_W-1:0]   room;
    logic [TAKE_W-1:0]   take;
    logic [15:0]         merged;
    logic [BYTE_W-1:0]   new_acc;
    logic [TAKE_W-1:0]   new_cnt;
    logic [COUNT_W-1:0]  rem_after;
    logic [SHAMT_W-1:0]  sh_amount;
    logic [FIELD_W-1:0]  sh_out;
    logic                emit;
    logic                step_go;
    logic                out_free;
    out_beat_t           beat;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_value      = s_axis_tdata[FIELD_W-1:0];
    assign in_count      = (s_axis_tdata[FIELD_W+COUNT_W-1:FIELD_W] > MAX_BITS) ?
                           MAX_BITS : s_axis_tdata[FIELD_W+COUNT_W-1:FIELD_W];
    assign opt_num       = in_value[ONB-1:0];
    assign opt_diff      = {1'b0, opt_num} - {1'b0, prev_reg};

    assign room      = BYTE_BITS - {1'b0, cnt_reg};
    assign take      = (rem_reg < {{(COUNT_W-TAKE_W){1'b0}}, room}) ?
                       rem_reg[TAKE_W-1:0] : room;
    assign merged    = {1'b0, acc_reg, val_reg[FIELD_W-1:FIELD_W-BYTE_W]} << take;
    assign new_acc   = merged[15:8];
    assign new_cnt   = {1'b0, cnt_reg} + take;
    assign rem_after = rem_reg - {{(COUNT_W-TAKE_W){1'b0}}, take};
    assign sh_amount = (state_reg == ST_ALIGN) ? (MAX_BITS - rem_reg) :
                       {{(SHAMT_W-TAKE_W){1'b0}}, take};

    cmbp_shift_unit u_shift (
        .din    (val_reg),
        .amount (sh_amount),
        .dout   (sh_out)
    );

    always_comb
    begin
        emit               = 1'b0;
        beat.out_byte      = new_acc;
        beat.run_last      = 1'b0;
        beat.message_last  = 1'b0;
        if (new_cnt == BYTE_BITS)
        begin
            emit              = 1'b1;
            beat.run_last     = (rem_after == '0) ||
                                (!end_reg &&
                                 (rem_after < {{(COUNT_W-TAKE_W){1'b0}}, BYTE_BITS}));
            beat.message_last = (rem_after == '0) && end_reg;
        end
        else if (end_reg && (new_cnt != '0))
        begin
            emit              = 1'b1;
            beat.out_byte     = new_acc << (BYTE_BITS - new_cnt);
            beat.run_last     = 1'b1;
            beat.message_last = 1'b1;
        end
    end

    assign step_go = (state_reg == ST_RUN) && (!emit || out_free);

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        end_next   = end_reg;
        prev_next  = prev_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rem_next   = in_count;
                    end_next   = s_axis_tlast;
                    state_next = ST_ALIGN;
                    if (s_axis_tuser)
                    begin
                        val_next  = {{(FIELD_W-ONB-1){opt_diff[ONB]}}, opt_diff};
                        prev_next = s_axis_tlast ? '0 : opt_num;
                    end
                    else
                    begin
                        val_next = in_value;
                        if (s_axis_tlast)
                        begin
                            prev_next = '0;
                        end
                    end
                end
            end
            ST_ALIGN:
            begin
                val_next   = sh_out;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (step_go)
                begin
                    val_next = sh_out;
                    rem_next = rem_after;
                    if ((new_cnt == BYTE_BITS) || end_reg)
                    begin
                        acc_next = '0;
                        cnt_next = '0;
                    end
                    else
                    begin
                        acc_next = new_acc[PEND_W-1:0];
                        cnt_next = new_cnt[PCNT_W-1:0];
                    end
                    if (rem_after == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            prev_reg  <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rem_reg <= rem_next;
        end_reg <= end_next;
    end

    cmbp_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (step_go && emit),
        .load_beat     (beat),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[rtl/cmbp_shift_unit.sv]
// Shared 64-bit left shifter of the bit packer.
// Depends on cmbp_pkg for widths.
module cmbp_shift_unit
    import cmbp_pkg::*;
(
    input  logic [FIELD_W-1:0] din,
    input  logic [SHAMT_W-1:0] amount,
    output logic [FIELD_W-1:0] dout
);

    always_comb
    begin
        if (amount >= MAX_BITS)
        begin
            dout = '0;
        end
        else
        begin
            dout = din << amount[SHAMT_W-2:0];
        end
    end

endmodule

[rtl/cmbp_out_stage.sv]
// Output register of the bit packer: holds one result beat until taken.
// Depends on cmbp_pkg for out_beat_t.
module cmbp_out_stage
    import cmbp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  out_beat_t         load_beat,
    output logic              free,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [BYTE_W-1:0] m_axis_tdata, // out_byte
    output logic              m_axis_tlast, // run_last
    output logic              m_axis_tuser  // message_last
);

    logic      valid_reg;
    out_beat_t beat_reg;

    assign free = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            beat_reg <= load_beat;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = beat_reg.out_byte;
    assign m_axis_tlast  = beat_reg.run_last;
    assign m_axis_tuser  = beat_reg.message_last;

endmodule
